@@ src/mts_pkg.sv @@
// ----------------------------------------------------------------------------
// mts_pkg: shared constants for the minimum-tracking stack
// Command and status codes and the default sizes of the stack.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int MTS_DEPTH      = 64;
  localparam int MTS_VALUE_BITS = 32;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_POP_EMPTY = 2'd1;
  localparam status_t STATUS_PUSH_FULL = 2'd2;

endpackage

@@ src/mts_ram.sv @@
// ----------------------------------------------------------------------------
// mts_ram: entry store of the minimum-tracking stack
// Single-port-write, single-port-read synchronous memory with registered
// read data.
// ----------------------------------------------------------------------------
module mts_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 34
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/min_tracking_stack.sv @@
// ----------------------------------------------------------------------------
// min_tracking_stack: bounded stack of signed values with O(1) minimum
// A push below the current minimum stores 2*value-min and makes the value
// the new minimum; popping such an entry restores min as 2*min-entry.
//
//   Channel  Ports                                   Handshake
//   input    in_cmd, in_value                        start high while busy low
//   result   out_popped_value, out_top_value,        out_valid, one cycle,
//            out_min_value, out_is_empty, out_status  no back-pressure
//
// A command is captured in ST_IDLE, whose accept edge also reads the entry
// below the top from the store; ST_EXEC then updates count, minimum and the
// cached top entry, writes a pushed entry and registers the result beat.
// A new command can be accepted in the cycle its result beat is shown.
// Reset empties the stack at once; the store needs no clearing pass, since
// only entries below the count are ever used.
// ----------------------------------------------------------------------------
module min_tracking_stack
  import mts_pkg::*;
#(
  parameter int DEPTH      = MTS_DEPTH,
  parameter int VALUE_BITS = MTS_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_cmd,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_valid,
  output logic signed [VALUE_BITS-1:0] out_popped_value,
  output logic signed [VALUE_BITS-1:0] out_top_value,
  output logic signed [VALUE_BITS-1:0] out_min_value,
  output logic                         out_is_empty,
  output logic [1:0]                   out_status
);

  localparam int W  = VALUE_BITS;
  localparam int EW = VALUE_BITS + 2;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t              state_r;
  logic                cmd_r;
  logic signed [W-1:0] value_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic signed [W-1:0] min_r, min_nxt;
  logic signed [EW-1:0] top_r, top_nxt;

  logic                out_valid_r;
  logic signed [W-1:0] popped_r, popped_nxt;
  logic signed [W-1:0] topv_r, topv_nxt;
  logic signed [W-1:0] minv_r, minv_nxt;
  logic                empty_r;
  status_t             status_r, status_nxt;

  logic                 accept;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic signed [EW-1:0] enc;
  logic [AW-1:0]        rd_addr;
  logic [EW-1:0]        rd_data;
  logic signed [EW-1:0] val_ext, min_ext, min_nxt_ext;

  assign busy   = (state_r == ST_EXEC);
  assign accept = start && !busy;

  // The entry below the top becomes the new top on a pop.
  assign rd_addr = AW'(count_r - CW'(2));
  assign wr_addr = count_r[AW-1:0];

  mts_ram #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (enc),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    val_ext    = EW'(value_r);
    min_ext    = EW'(min_r);
    count_nxt  = count_r;
    min_nxt    = min_r;
    top_nxt    = top_r;
    popped_nxt = '0;
    status_nxt = STATUS_OK;
    wr_en      = 1'b0;
    enc        = val_ext;
    case (cmd_r)
      CMD_PUSH: begin
        if (count_r == CW'(DEPTH)) begin
          status_nxt = STATUS_PUSH_FULL;
        end else begin
          wr_en = (state_r == ST_EXEC);
          if (count_r == '0) begin
            min_nxt = value_r;
          end else if (value_r < min_r) begin
            enc     = (val_ext <<< 1) - min_ext;
            min_nxt = value_r;
          end
          top_nxt   = enc;
          count_nxt = count_r + CW'(1);
        end
      end
      CMD_POP: begin
        if (count_r == '0) begin
          status_nxt = STATUS_POP_EMPTY;
        end else begin
          if (top_r < min_ext) begin
            popped_nxt = min_r;
            min_nxt    = W'((min_ext <<< 1) - top_r);
          end else begin
            popped_nxt = top_r[W-1:0];
          end
          top_nxt   = rd_data;
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        status_nxt = STATUS_OK;
      end
    endcase

    min_nxt_ext = EW'(min_nxt);
    topv_nxt    = '0;
    minv_nxt    = '0;
    if (count_nxt != '0) begin
      topv_nxt = (top_nxt < min_nxt_ext) ? min_nxt : top_nxt[W-1:0];
      minv_nxt = min_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      min_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          out_valid_r <= 1'b0;
          if (accept) begin
            cmd_r   <= in_cmd;
            value_r <= in_value;
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          count_r     <= count_nxt;
          min_r       <= min_nxt;
          top_r       <= top_nxt;
          popped_r    <= popped_nxt;
          topv_r      <= topv_nxt;
          minv_r      <= minv_nxt;
          empty_r     <= (count_nxt == '0);
          status_r    <= status_nxt;
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = popped_r;
  assign out_top_value    = topv_r;
  assign out_min_value    = minv_r;
  assign out_is_empty     = empty_r;
  assign out_status       = status_r;

  // Every executed command yields exactly one result beat.
  a_exec_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |=> out_valid)
    else $error("command executed without a result beat");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond the stack depth");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_min_value == '0 && out_top_value == '0))
    else $error("empty stack reports a nonzero top or minimum");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_PUSH_FULL) |-> (count_r == CW'(DEPTH)))
    else $error("push-on-full flagged while the stack is not full");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_POP_EMPTY) |-> (out_is_empty && out_popped_value == '0))
    else $error("pop-on-empty flagged on a nonempty stack");

endmodule
